### rtl/tti_pkg.sv
// Shared constants and types for the text-to-integer parser with a custom digit alphabet.
`timescale 1ns / 1ps
`default_nettype none

package tti_pkg;

   localparam int MaxSymbols   = 64;
   localparam int AlphaWords   = 8;
   localparam int AlphaWordW   = 64;
   localparam int SymbolW      = 8;
   localparam int AlphaBits    = AlphaWords * AlphaWordW;
   localparam int CsrIndexW    = $clog2(AlphaWords);
   localparam int DigitW       = (MaxSymbols > 2) ? $clog2(MaxSymbols) : 1;
   localparam int LenW         = $clog2(MaxSymbols + 1);
   localparam int ValueW       = 32;

   localparam logic [SymbolW-1:0] CharMinus    = 8'h2D;
   localparam logic [SymbolW-1:0] CharPlus     = 8'h2B;
   localparam logic [SymbolW-1:0] CharFirstVis = 8'h21;
   localparam logic [SymbolW-1:0] CharLastVis  = 8'h7E;
   localparam logic [SymbolW-1:0] CharTab      = 8'h09;
   localparam logic [SymbolW-1:0] CharCr       = 8'h0D;
   localparam logic [SymbolW-1:0] CharSpace    = 8'h20;
   localparam logic [SymbolW-1:0] CharNul      = 8'h00;

   typedef enum logic [1:0] {
      PHASE_SPACE = 2'd0,
      PHASE_SIGN  = 2'd1,
      PHASE_DIGIT = 2'd2,
      PHASE_DONE  = 2'd3
   } phase_type;

endpackage

`default_nettype wire

### rtl/text_to_integer_custom_radix_top.sv
// Top level of the text-to-integer parser: alphabet check, character parse and result register.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_character[7:0], req_last
//   rsp      out        rsp_valid / rsp_stall  rsp_value[31:0] signed, rsp_base_error
//   csr      in         csr_write              csr_index[2:0], csr_wdata[63:0]
//
// One character per cycle while req_stall is low: a word goes from the input register through one alphabet
// compare and one 32x7 multiply-add into the parse state and the result register.
// Each alphabet write starts a scan of the alphabet, one symbol a cycle, over all 64
// symbol slots; req_stall stays high until it ends. Reset (synchronous) needs no scan.
// A last word waits in the input register while a result is still stalled.
`timescale 1ns / 1ps
`default_nettype none

module text_to_integer_custom_radix_top (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire  [tti_pkg::SymbolW-1:0]           req_character,
   input  wire                                   req_last,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic signed [tti_pkg::ValueW-1:0]     rsp_value,
   output logic                                  rsp_base_error,
   input  wire                                   csr_write,
   input  wire  [tti_pkg::CsrIndexW-1:0]         csr_index,
   input  wire  [tti_pkg::AlphaWordW-1:0]        csr_wdata
);

   localparam int SymW = tti_pkg::SymbolW;
   localparam int Max  = tti_pkg::MaxSymbols;
   localparam int DW   = tti_pkg::DigitW;
   localparam int LW   = tti_pkg::LenW;
   localparam int VW   = tti_pkg::ValueW;

   // alphabet registers and scan
   logic [tti_pkg::AlphaBits-1:0] alpha_ff, alpha_in;
   logic [tti_pkg::AlphaBits-1:0] shadow_ff, shadow_in;
   logic                          busy_ff, busy_in;
   logic [DW-1:0]                 cnt_ff, cnt_in;
   logic                          ended_ff, ended_in;
   logic                          bad_ff, bad_in;
   logic [LW-1:0]                 len_ff, len_in;
   logic [Max-1:0]                mask_ff, mask_in;
   logic                          start;
   logic [SymW-1:0]               head;
   logic                          head_dup;

   // input register
   logic                          in_vld_ff, in_vld_in;
   logic [SymW-1:0]               in_char_ff;
   logic                          in_last_ff;
   logic                          accept;
   logic                          advance;

   // parse state
   tti_pkg::phase_type            phase_ff, phase_in;
   logic                          neg_ff, neg_in;
   logic [VW-1:0]                 acc_ff, acc_in;

   // result register
   logic                          out_vld_ff, out_vld_in;
   logic [VW-1:0]                 out_value_ff, out_value_in;
   logic                          out_err_ff, out_err_in;

   logic                          is_space, is_sign, found;
   logic                          sel_space, sel_sign, sel_digit;
   logic [Max-1:0]                hit;
   logic [DW-1:0]                 digit;
   logic [VW-1:0]                 acc_step, signed_acc;
   logic                          alpha_err;

   // ---------------- alphabet write and scan ----------------
   always_comb begin
      alpha_in = alpha_ff;
      start    = 1'b0;
      for (int k = 0; k < tti_pkg::AlphaWords; k++) begin
         if (csr_write && csr_index == tti_pkg::CsrIndexW'(k)) begin
            alpha_in[k*tti_pkg::AlphaWordW +: tti_pkg::AlphaWordW] = csr_wdata;
            start = 1'b1;
         end
      end
   end

   assign head = shadow_ff[SymW-1:0];

   always_comb begin
      head_dup = 1'b0;
      for (int j = 0; j < Max; j++) begin
         if (mask_ff[j] && alpha_ff[j*SymW +: SymW] == head) begin
            head_dup = 1'b1;
         end
      end
   end

   always_comb begin
      shadow_in = shadow_ff;
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      ended_in  = ended_ff;
      bad_in    = bad_ff;
      len_in    = len_ff;
      mask_in   = mask_ff;
      if (start) begin
         // restart the scan on the new alphabet
         shadow_in = alpha_in;
         busy_in   = 1'b1;
         cnt_in    = '0;
         ended_in  = 1'b0;
         bad_in    = 1'b0;
         len_in    = '0;
         mask_in   = '0;
      end else if (busy_ff) begin
         shadow_in = shadow_ff >> SymW;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == DW'(Max - 1)) begin
            busy_in = 1'b0;
         end
         if (!ended_ff) begin
            if (head == tti_pkg::CharNul) begin
               ended_in = 1'b1;
            end else begin
               mask_in[cnt_ff] = 1'b1;
               len_in          = len_ff + 1'b1;
               if (head == tti_pkg::CharPlus || head == tti_pkg::CharMinus ||
                   head < tti_pkg::CharFirstVis || head > tti_pkg::CharLastVis ||
                   head_dup) begin
                  bad_in = 1'b1;
               end
            end
         end
      end
   end

   assign alpha_err = bad_ff || (len_ff < LW'(2));

   // ---------------- handshake ----------------
   assign accept    = req_valid && !req_stall;
   assign advance   = in_vld_ff && !(in_last_ff && out_vld_ff && rsp_stall);
   assign req_stall = busy_ff || (in_vld_ff && !advance);

   always_comb begin
      in_vld_in = in_vld_ff;
      if (accept) begin
         in_vld_in = 1'b1;
      end else if (advance) begin
         in_vld_in = 1'b0;
      end
   end

   // ---------------- character classification ----------------
   assign is_space = (in_char_ff >= tti_pkg::CharTab && in_char_ff <= tti_pkg::CharCr) ||
                     in_char_ff == tti_pkg::CharSpace;
   assign is_sign  = in_char_ff == tti_pkg::CharPlus || in_char_ff == tti_pkg::CharMinus;

   always_comb begin
      digit = '0;
      for (int i = 0; i < Max; i++) begin
         hit[i] = mask_ff[i] && alpha_ff[i*SymW +: SymW] == in_char_ff;
         // a duplicate forces a zero result, so an OR of the indexes is enough
         if (hit[i]) begin
            digit = digit | DW'(i);
         end
      end
   end

   assign found = |hit;

   assign sel_space = phase_ff == tti_pkg::PHASE_SPACE && is_space;
   assign sel_sign  = !sel_space && is_sign &&
                      (phase_ff == tti_pkg::PHASE_SPACE || phase_ff == tti_pkg::PHASE_SIGN);
   assign sel_digit = !sel_space && !sel_sign && phase_ff != tti_pkg::PHASE_DONE && found;

   // ---------------- next phase ----------------
   always_comb begin
      phase_in = phase_ff;
      if (advance) begin
         if (in_last_ff) begin
            phase_in = tti_pkg::PHASE_SPACE;
         end else if (sel_space) begin
            phase_in = phase_ff;
         end else if (sel_sign) begin
            phase_in = tti_pkg::PHASE_SIGN;
         end else if (sel_digit) begin
            phase_in = tti_pkg::PHASE_DIGIT;
         end else begin
            phase_in = tti_pkg::PHASE_DONE;
         end
      end
   end

   // ---------------- accumulate and result ----------------
   assign acc_step = acc_ff * {{(VW - LW){1'b0}}, len_ff} + {{(VW - DW){1'b0}}, digit};

   always_comb begin
      neg_in       = neg_ff;
      acc_in       = acc_ff;
      out_vld_in   = out_vld_ff;
      out_value_in = out_value_ff;
      out_err_in   = out_err_ff;
      signed_acc   = '0;
      if (!rsp_stall) begin
         out_vld_in = 1'b0;
      end
      if (advance) begin
         if (sel_sign && in_char_ff == tti_pkg::CharMinus) begin
            neg_in = !neg_ff;
         end
         if (sel_digit) begin
            acc_in = acc_step;
         end
         signed_acc = neg_in ? (VW'(0) - acc_in) : acc_in;
         if (in_last_ff) begin
            out_vld_in   = 1'b1;
            out_value_in = alpha_err ? '0 : signed_acc;
            out_err_in   = alpha_err;
            // drop the parse state for the next text
            neg_in       = 1'b0;
            acc_in       = '0;
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff   <= '0;
         busy_ff    <= 1'b0;
         cnt_ff     <= '0;
         ended_ff   <= 1'b0;
         bad_ff     <= 1'b0;
         len_ff     <= '0;
         mask_ff    <= '0;
         in_vld_ff  <= 1'b0;
         phase_ff   <= tti_pkg::PHASE_SPACE;
         neg_ff     <= 1'b0;
         acc_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         alpha_ff   <= alpha_in;
         busy_ff    <= busy_in;
         cnt_ff     <= cnt_in;
         ended_ff   <= ended_in;
         bad_ff     <= bad_in;
         len_ff     <= len_in;
         mask_ff    <= mask_in;
         in_vld_ff  <= in_vld_in;
         phase_ff   <= phase_in;
         neg_ff     <= neg_in;
         acc_ff     <= acc_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      shadow_ff    <= shadow_in;
      out_value_ff <= out_value_in;
      out_err_ff   <= out_err_in;
      if (accept) begin
         in_char_ff <= req_character;
         in_last_ff <= req_last;
      end
   end

   assign rsp_valid      = out_vld_ff;
   assign rsp_value      = out_value_ff;
   assign rsp_base_error = out_err_ff;

endmodule

`default_nettype wire

### test/tti_check_pkg.sv
// Scoreboard that predicts the parsed integers and checks the parser's results.
`timescale 1ns / 1ps

package tti_check_pkg;
   import tti_pkg::*;

   typedef struct packed {
      logic signed [ValueW-1:0] value;
      logic                     base_error;
   } parse_result_t;

   class parse_scoreboard;
      logic [AlphaBits-1:0] alphabet;
      phase_type            phase;
      logic                 minus_odd;
      logic [ValueW-1:0]    acc;
      parse_result_t        expected_q[$];
      int                   errors;

      function new();
         alphabet  = '0;
         phase     = PHASE_SPACE;
         minus_odd = 1'b0;
         acc       = '0;
         errors    = 0;
      endfunction

      function void set_word(int idx, logic [AlphaWordW-1:0] data);
         alphabet[idx*AlphaWordW +: AlphaWordW] = data;
      endfunction

      function logic [SymbolW-1:0] symbol(int i);
         return alphabet[i*SymbolW +: SymbolW];
      endfunction

      function int symbol_count();
         int n;
         n = 0;
         while (n < MaxSymbols && symbol(n) != CharNul) n++;
         return n;
      endfunction

      function bit alphabet_invalid(int len);
         int i, j;
         logic [SymbolW-1:0] s;
         if (len < 2) return 1'b1;
         for (i = 0; i < len; i++) begin
            s = symbol(i);
            if (s == CharPlus || s == CharMinus || s < CharFirstVis || s > CharLastVis)
               return 1'b1;
         end
         for (i = 0; i < len; i++)
            for (j = i + 1; j < len; j++)
               if (symbol(i) == symbol(j)) return 1'b1;
         return 1'b0;
      endfunction

      // Advance the parse on one accepted word; queue the result on a last word.
      function void take_char(logic [SymbolW-1:0] c, logic last);
         int len, digit, i;
         bit is_space, is_sign;
         parse_result_t r;
         len      = symbol_count();
         is_space = (c >= CharTab && c <= CharCr) || c == CharSpace;
         is_sign  = (c == CharPlus) || (c == CharMinus);
         digit    = -1;
         for (i = 0; i < len; i++)
            if (digit < 0 && symbol(i) == c) digit = i;

         if (phase == PHASE_SPACE && is_space) begin
            // hold in whitespace
         end else if ((phase == PHASE_SPACE || phase == PHASE_SIGN) && is_sign) begin
            phase = PHASE_SIGN;
            if (c == CharMinus) minus_odd = ~minus_odd;
         end else if (phase != PHASE_DONE && digit >= 0) begin
            phase = PHASE_DIGIT;
            acc   = acc * ValueW'(len) + ValueW'(digit);
         end else begin
            phase = PHASE_DONE;
         end

         if (last) begin
            r.base_error = alphabet_invalid(len);
            r.value      = minus_odd ? (ValueW'(0) - acc) : acc;
            if (r.base_error) r.value = '0;
            expected_q.push_back(r);
            phase     = PHASE_SPACE;
            minus_odd = 1'b0;
            acc       = '0;
         end
      endfunction

      function void check_result(logic signed [ValueW-1:0] value, logic base_error);
         parse_result_t r;
         if (expected_q.size() == 0) begin
            $error("result with none pending: value %0d base_error %0d", value, base_error);
            errors++;
            return;
         end
         r = expected_q.pop_front();
         if (value !== r.value) begin
            $error("value: expected %0d, got %0d", r.value, value);
            errors++;
         end
         if (base_error !== r.base_error) begin
            $error("base_error: expected %0d, got %0d", r.base_error, base_error);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

endpackage

### test/text_to_integer_custom_radix_top_test.sv
// Top-level test of the text-to-integer parser: stimulus, idling, result checks and watchdog.
`timescale 1ns / 1ps

module text_to_integer_custom_radix_top_test;
   import tti_pkg::*;
   import tti_check_pkg::*;

   localparam int IdleLimit     = 3000;
   localparam int DrainCycles   = 20;
   localparam int HoldOffCycles = 300;
   localparam int TextItems     = 1750;
   localparam int HoldOffAt     = 30;
   localparam int HoldOffEvery  = 97;

   localparam logic [AlphaBits-1:0] Decimal = "9876543210";

   logic                     clock          = 1'b0;
   logic                     reset          = 1'b1;
   logic                     req_valid      = 1'b0;
   logic                     req_stall;
   logic [SymbolW-1:0]       req_character  = '0;
   logic                     req_last       = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall      = 1'b1;
   logic signed [ValueW-1:0] rsp_value;
   logic                     rsp_base_error;
   logic                     csr_write      = 1'b0;
   logic [CsrIndexW-1:0]     csr_index      = '0;
   logic [AlphaWordW-1:0]    csr_wdata      = '0;

   parse_scoreboard board;
   int req_gap_max  = 17;
   int rsp_gap_max  = 17;
   int results_seen = 0;
   int idle_cycles  = 0;
   int sent_count   = 0;

   text_to_integer_custom_radix_top i_dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int pick_gap_max();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 2;
         default: return 17;
      endcase
   endfunction

   function automatic logic [SymbolW-1:0] random_space();
      int r;
      r = $urandom_range(0, 5);
      return (r == 5) ? CharSpace : CharTab + SymbolW'(r);
   endfunction

   function automatic logic [SymbolW-1:0] random_sign();
      return $urandom_range(0, 1) ? CharMinus : CharPlus;
   endfunction

   function automatic logic [SymbolW-1:0] random_digit();
      int len;
      len = board.symbol_count();
      if (len == 0) return SymbolW'($urandom);
      return board.symbol($urandom_range(0, len - 1));
   endfunction

   // Build an alphabet: shuffled printable non-sign symbols, then an optional flaw.
   function automatic logic [AlphaBits-1:0] pick_alphabet(int kind);
      logic [SymbolW-1:0]   pool[92];
      logic [SymbolW-1:0]   t;
      logic [AlphaBits-1:0] flat;
      int n, len, i, j;
      n = 0;
      for (i = CharFirstVis; i <= CharLastVis; i++)
         if (i != CharPlus && i != CharMinus) begin
            pool[n] = SymbolW'(i);
            n++;
         end
      for (i = n - 1; i > 0; i--) begin
         j       = $urandom_range(0, i);
         t       = pool[i];
         pool[i] = pool[j];
         pool[j] = t;
      end
      if (kind == 9)
         len = MaxSymbols;
      else if ($urandom_range(0, 3) == 0)
         len = $urandom_range(2, MaxSymbols);
      else
         len = $urandom_range(2, 16);
      flat = '0;
      for (i = 0; i < len; i++) flat[i*SymbolW +: SymbolW] = pool[i];
      i = $urandom_range(0, len - 1);
      case (kind)
         10: flat = '0;
         11: flat = '1;
         12: flat[AlphaBits-1:SymbolW] = '0;
         13: flat[i*SymbolW +: SymbolW] = random_sign();
         14: flat[i*SymbolW +: SymbolW] = $urandom_range(0, 1) ?
                SymbolW'($urandom_range(1, 32)) : SymbolW'($urandom_range(127, 255));
         15: begin
            j = (i + 1 + $urandom_range(0, len - 2)) % len;
            flat[j*SymbolW +: SymbolW] = flat[i*SymbolW +: SymbolW];
         end
         default: ;
      endcase
      return flat;
   endfunction

   task automatic release_req();
      req_valid <= 1'b0;
   endtask

   // Offer one word after a random gap and hold it until accepted.
   task automatic push_char(input logic [SymbolW-1:0] c, input logic last);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_character <= c;
      req_last      <= last;
      do @(posedge clock); while (req_stall);
      board.take_char(c, last);
      sent_count++;
   endtask

   task automatic load_alphabet(input logic [AlphaBits-1:0] flat,
                                input logic [AlphaWords-1:0] mask);
      int k;
      for (k = 0; k < AlphaWords; k++)
         if (mask[k]) begin
            csr_write <= 1'b1;
            csr_index <= CsrIndexW'(k);
            csr_wdata <= flat[k*AlphaWordW +: AlphaWordW];
            @(posedge clock);
            board.set_word(k, flat[k*AlphaWordW +: AlphaWordW]);
         end
      csr_write <= 1'b0;
   endtask

   // Drain all results, then let the parse pipeline settle.
   task automatic sync_idle();
      release_req();
      while (board.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic send_text();
      logic [SymbolW-1:0] text[$];
      int form, i;
      form = $urandom_range(0, 19);
      if (form < 14) begin
         repeat ($urandom_range(0, 3)) text.push_back(random_space());
         repeat ($urandom_range(0, 3)) text.push_back(random_sign());
         repeat ($urandom_range(0, 12)) text.push_back(random_digit());
         if ($urandom_range(0, 1)) begin
            text.push_back($urandom_range(0, 3) == 0 ? CharNul : SymbolW'($urandom));
            repeat ($urandom_range(0, 2)) text.push_back(SymbolW'($urandom));
         end
      end else if (form < 17) begin
         // jumble the classes so signs and spaces land after digits
         repeat ($urandom_range(1, 10))
            case ($urandom_range(0, 3))
               0: text.push_back(random_space());
               1: text.push_back(random_sign());
               2: text.push_back(random_digit());
               default: text.push_back(SymbolW'($urandom));
            endcase
      end else begin
         repeat ($urandom_range(1, 8)) text.push_back(SymbolW'($urandom));
      end
      if (text.size() == 0) text.push_back(random_digit());
      for (i = 0; i < text.size(); i++) push_char(text[i], i == text.size() - 1);
   endtask

   initial begin
      int gap;
      while (reset) @(posedge clock);
      forever begin
         gap = $urandom_range(0, rsp_gap_max);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         board.check_result(rsp_value, rsp_base_error);
         results_seen++;
         // hold off long enough for the parser to back up its input
         if (results_seen % HoldOffEvery == HoldOffAt) begin
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
         end
      end
   end

   initial begin
      logic [AlphaWordW-1:0] word;
      int k;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty alphabet after reset
      push_char("7", 1'b1);
      sync_idle();
      load_alphabet(Decimal, '1);

      // whitespace, sign run with an even count of minus signs, digit, zero byte ends the number
      push_char(CharTab, 1'b0);
      push_char(CharMinus, 1'b0);
      push_char(CharPlus, 1'b0);
      push_char(CharMinus, 1'b0);
      push_char("4", 1'b0);
      push_char(CharNul, 1'b0);
      push_char("7", 1'b1);
      // digitless negated text
      push_char(CharMinus, 1'b1);

      // alphabet shrinks to octal in the middle of a text
      push_char("1", 1'b0);
      push_char("2", 1'b0);
      sync_idle();
      load_alphabet('0, 8'h02);
      push_char("7", 1'b1);

      // full alphabet: wrap to all ones, then the most negative value
      sync_idle();
      load_alphabet(pick_alphabet(9), '1);
      push_char(board.symbol(3), 1'b0);
      for (k = 0; k < 5; k++) push_char(board.symbol(MaxSymbols - 1), k == 4);
      push_char(CharMinus, 1'b0);
      push_char(board.symbol(2), 1'b0);
      for (k = 0; k < 5; k++) push_char(board.symbol(0), k == 4);

      while (sent_count < TextItems) begin
         sync_idle();
         if ($urandom_range(0, 9) == 0) begin
            word = {$urandom, $urandom};
            load_alphabet({AlphaWords{word}}, AlphaWords'(1) << $urandom_range(0, 7));
         end else begin
            load_alphabet(pick_alphabet($urandom_range(0, 15)), '1);
         end
         repeat ($urandom_range(5, 25)) begin
            req_gap_max = pick_gap_max();
            rsp_gap_max = pick_gap_max();
            send_text();
         end
      end

      release_req();
      while (board.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      board.errors += board.pending();
      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
